### rtl/hss_pkg.sv
`timescale 1ns / 1ps

package hss_pkg;

    // Default grid side and derived widths of the stencil arithmetic.
    localparam int DEFAULT_MAX_GRID = 1024;
    localparam int VALUE_W = 32;
    localparam int RATIO_W = 16;
    localparam int GRID_W = 11;
    localparam int WEIGHT_W = RATIO_W + 3;
    localparam int SUM_W = VALUE_W + 2;
    localparam int PROD_W = WEIGHT_W + VALUE_W;
    localparam int ACC_W = PROD_W + 1;
    localparam int RES_W = ACC_W - RATIO_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_SIZE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_RATIO = 1'd1;
    localparam logic [GRID_W-1:0] GRID_SIZE_RESET = 11'd1024;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd6554;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [VALUE_W-1:0] value_t;

    // One cell update: the five stencil operands, already masked at the edges.
    typedef struct packed {
        value_t centre;
        value_t above;
        value_t left;
        value_t right;
        value_t below;
        logic   last;
    } item_t;

endpackage

### rtl/hss_front.sv
`timescale 1ns / 1ps

module hss_front #(
    parameter int MAX_GRID = hss_pkg::DEFAULT_MAX_GRID
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hss_pkg::VALUE_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic [$clog2(MAX_GRID+1)-1:0]     side,
    input  logic                              restart,
    input  logic [hss_pkg::QCNT_W-1:0]        q_count,
    output logic                              push,
    output hss_pkg::item_t                    push_item
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);

    // Each line buffer word holds {row j-2, row j-1} of one column.
    logic [2*hss_pkg::VALUE_W-1:0] line_mem [MAX_GRID];

    logic [CW-1:0]       col_reg, col_next;
    logic [NW-1:0]       row_reg, row_next;
    logic [NW-1:0]       col_p1;
    logic                accept;
    logic                last_col;
    logic                row_is_pad;
    hss_pkg::value_t     in_val;
    hss_pkg::value_t     cur_centre;
    hss_pkg::value_t     cur_above;
    hss_pkg::value_t     rd_hi_reg, rd_lo_reg;
    hss_pkg::value_t     col0_a_reg, col0_b_reg;
    hss_pkg::value_t     left_reg;
    hss_pkg::item_t      s1_item_reg, s1_item_next;
    logic                s1_valid_reg;
    logic                s1_right_ok_reg;
    logic [hss_pkg::QCNT_W:0] q_load;

    // Accept only while the queue has room for this item and the one in flight.
    assign q_load = (hss_pkg::QCNT_W+1)'(q_count) + (hss_pkg::QCNT_W+1)'(s1_valid_reg);
    assign s_axis_tready = q_load < (hss_pkg::QCNT_W+1)'(hss_pkg::QUEUE_DEPTH);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Classify the item: position, padding and edge masks.
    assign col_p1 = NW'(col_reg) + NW'(1);
    assign last_col = (col_p1 == side);
    assign row_is_pad = (row_reg == side);
    assign in_val = (s_axis_tuser || row_is_pad) ? '0 : s_axis_tdata;
    assign cur_centre = (col_reg == '0) ? col0_a_reg : rd_lo_reg;
    assign cur_above = (col_reg == '0) ? col0_b_reg : rd_hi_reg;

    always_comb
    begin
        s1_item_next.centre = cur_centre;
        s1_item_next.above = (row_reg >= NW'(2)) ? cur_above : '0;
        s1_item_next.left = (col_reg != '0) ? left_reg : '0;
        s1_item_next.right = '0;
        s1_item_next.below = in_val;
        s1_item_next.last = row_is_pad && last_col;
    end

    // Raster position of the next item.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = row_is_pad ? '0 : row_reg + NW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            s1_valid_reg <= accept && (row_reg != '0);
        end
    end

    // Line buffer: store this column, fetch the next one for the right neighbor.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= {cur_centre, in_val};
            {rd_hi_reg, rd_lo_reg} <= line_mem[col_p1[CW-1:0]];
        end
    end

    // Column zero is kept in registers, the previous centre serves as left.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg <= cur_centre;
            s1_item_reg <= s1_item_next;
            s1_right_ok_reg <= !last_col;
            if (col_reg == '0)
            begin
                col0_b_reg <= col0_a_reg;
                col0_a_reg <= in_val;
            end
        end
    end

    // The right neighbor arrives from the line buffer in the cycle after accept.
    always_comb
    begin
        push = s1_valid_reg;
        push_item = s1_item_reg;
        push_item.right = s1_right_ok_reg ? rd_lo_reg : '0;
    end

endmodule

### rtl/hss_fifo.sv
`timescale 1ns / 1ps

module hss_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  hss_pkg::item_t              push_item,
    input  logic                        pop,
    output logic                        pop_valid,
    output hss_pkg::item_t              pop_item,
    output logic [hss_pkg::QCNT_W-1:0]  count
);

    hss_pkg::item_t               slot_mem [hss_pkg::QUEUE_DEPTH];
    logic [hss_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [hss_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [hss_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_pop;

    assign pop_valid = (count_reg != '0);
    assign pop_item = slot_mem[rd_ptr_reg];
    assign count = count_reg;
    assign do_pop = pop && pop_valid;

    // Pointers and fill level; the front never pushes into a full queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + hss_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + hss_pkg::QPTR_W'(1);
            end
            count_reg <= count_reg + hss_pkg::QCNT_W'(push) - hss_pkg::QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/hss_back.sv
`timescale 1ns / 1ps

module hss_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [hss_pkg::RATIO_W-1:0]      ratio,
    input  logic                             q_valid,
    input  hss_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hss_pkg::VALUE_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int VW = hss_pkg::VALUE_W;
    localparam int XW = hss_pkg::RES_W - VW + 1;
    localparam logic signed [hss_pkg::RES_W-1:0] SAT_HI = {{XW{1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [hss_pkg::RES_W-1:0] SAT_LO = {{XW{1'b1}}, {(VW-1){1'b0}}};

    logic                                 a_valid_reg, b_valid_reg, c_valid_reg, out_valid_reg;
    logic                                 a_adv, b_adv, c_adv, out_adv;
    logic signed [hss_pkg::SUM_W-1:0]     a_sum_reg, a_sum_next;
    hss_pkg::value_t                      a_centre_reg;
    logic                                 a_last_reg, b_last_reg, c_last_reg, out_last_reg;
    logic signed [hss_pkg::WEIGHT_W-1:0]  weight;
    logic signed [hss_pkg::RATIO_W:0]     ratio_s;
    logic signed [hss_pkg::PROD_W-1:0]    b_pc_reg, b_pn_reg;
    logic signed [hss_pkg::ACC_W-1:0]     c_acc_reg, c_acc_next;
    logic signed [hss_pkg::RES_W-1:0]     res;
    logic [VW-1:0]                        out_data_reg, out_data_next;

    // Advance a stage when the one after it is empty or moving.
    assign out_adv = !out_valid_reg || m_axis_tready;
    assign c_adv = !c_valid_reg || out_adv;
    assign b_adv = !b_valid_reg || c_adv;
    assign a_adv = !a_valid_reg || b_adv;
    assign q_pop = q_valid && a_adv;

    // Neighbor sum, then center weight 1 - 4r as signed Q2.16.
    assign a_sum_next = {{2{q_item.left[VW-1]}}, q_item.left}
                      + {{2{q_item.right[VW-1]}}, q_item.right}
                      + {{2{q_item.above[VW-1]}}, q_item.above}
                      + {{2{q_item.below[VW-1]}}, q_item.below};
    assign ratio_s = {1'b0, ratio};
    assign weight = (hss_pkg::WEIGHT_W)'(1 << hss_pkg::RATIO_W)
                  - $signed({1'b0, ratio, 2'b00});

    // Sum the two products, drop the ratio fraction with floor, then saturate.
    assign c_acc_next = {b_pc_reg[hss_pkg::PROD_W-1], b_pc_reg}
                      + {b_pn_reg[hss_pkg::PROD_W-1], b_pn_reg};
    assign res = c_acc_reg[hss_pkg::ACC_W-1:hss_pkg::RATIO_W];

    always_comb
    begin
        if (res > SAT_HI)
        begin
            out_data_next = SAT_HI[VW-1:0];
        end
        else if (res < SAT_LO)
        begin
            out_data_next = SAT_LO[VW-1:0];
        end
        else
        begin
            out_data_next = res[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= q_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_adv)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload of the arithmetic pipeline.
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_sum_reg <= a_sum_next;
            a_centre_reg <= q_item.centre;
            a_last_reg <= q_item.last;
        end
        if (b_adv)
        begin
            b_pc_reg <= hss_pkg::PROD_W'(weight) * hss_pkg::PROD_W'(a_centre_reg);
            b_pn_reg <= hss_pkg::PROD_W'(ratio_s) * hss_pkg::PROD_W'(a_sum_reg);
            b_last_reg <= a_last_reg;
        end
        if (c_adv)
        begin
            c_acc_reg <= c_acc_next;
            c_last_reg <= b_last_reg;
        end
        if (out_adv)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= c_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

endmodule

### rtl/heat_stencil_step_top.sv
`timescale 1ns / 1ps

// Channel   Signals                                 Payload
// s_axis    tvalid tready tdata tuser              cell_value, flush
// m_axis    tvalid tready tdata tlast              new_value, last_of_grid
// cfg       cfg_valid cfg_ready cfg_addr cfg_data  0: grid_size, 1: diffusion_ratio
//
// One cell is accepted per cycle while the queue has room; the line buffer is read at
// one address and written at another on each accept, which sets that rate.
// A result passes the front's staging register, the queue and the back's a, b, c and output registers.
// Reset clears positions, the queue and pipeline valids; the line buffer needs no clearing.
// A stalled output fills the four-entry queue; s_axis_tready drops once the queue and the item in flight fill it.

module heat_stencil_step_top #(
    parameter int MAX_GRID = hss_pkg::DEFAULT_MAX_GRID
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [hss_pkg::VALUE_W-1:0]        s_axis_tdata,   // [31:0] cell_value
    input  logic                               s_axis_tuser,   // [0] flush
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [hss_pkg::VALUE_W-1:0]        m_axis_tdata,   // [31:0] new_value
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NW = $clog2(MAX_GRID + 1);

    // Clamp a written size into 1..MAX_GRID.
    function automatic logic [NW-1:0] side_of(input logic [hss_pkg::GRID_W-1:0] gs);
        logic [31:0] g;
        logic [31:0] n;
        g = 32'(gs);
        n = g;
        if (g == 32'd0)
        begin
            n = 32'd1;
        end
        else if (g > 32'(MAX_GRID))
        begin
            n = 32'(MAX_GRID);
        end
        return n[NW-1:0];
    endfunction

    logic [NW-1:0]                   side_reg;
    logic [hss_pkg::RATIO_W-1:0]     ratio_reg;
    logic                            cfg_write;
    logic                            restart;
    logic                            push;
    hss_pkg::item_t                  push_item;
    logic                            pop;
    logic                            pop_valid;
    hss_pkg::item_t                  pop_item;
    logic [hss_pkg::QCNT_W-1:0]      q_count;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart = cfg_write && (cfg_addr == hss_pkg::REG_GRID_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= side_of(hss_pkg::GRID_SIZE_RESET);
            ratio_reg <= hss_pkg::RATIO_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                hss_pkg::REG_GRID_SIZE:
                begin
                    side_reg <= side_of(cfg_data[hss_pkg::GRID_W-1:0]);
                end
                hss_pkg::REG_DIFF_RATIO:
                begin
                    ratio_reg <= cfg_data[hss_pkg::RATIO_W-1:0];
                end
                default:
                begin
                    ratio_reg <= ratio_reg;
                end
            endcase
        end
    end

    hss_front #(
        .MAX_GRID(MAX_GRID)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .side(side_reg),
        .restart(restart),
        .q_count(q_count),
        .push(push),
        .push_item(push_item)
    );

    hss_fifo u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(push_item),
        .pop(pop),
        .pop_valid(pop_valid),
        .pop_item(pop_item),
        .count(q_count)
    );

    hss_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .ratio(ratio_reg),
        .q_valid(pop_valid),
        .q_item(pop_item),
        .q_pop(pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

endmodule
